// ===== design/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// Interface subnet table package
// Request and result types, controller command and status types, and the
// mode, mask source and status codes shared by the table's modules.
// ----------------------------------------------------------------------------
package ist_pkg;

  // Mode codes of a request.
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Where the netmask of an added entry comes from.
  localparam logic [1:0] MSRC_CLASSFUL = 2'd0;
  localparam logic [1:0] MSRC_PREFIX   = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  // Classful default netmasks.
  localparam logic [31:0] MASK_CLASS_A = 32'hFF00_0000;
  localparam logic [31:0] MASK_CLASS_B = 32'hFFFF_0000;
  localparam logic [31:0] MASK_CLASS_C = 32'hFFFF_FF00;
  localparam logic [31:0] MASK_CLASS_D = 32'hFFFF_FFF0;
  localparam logic [31:0] MASK_ONES    = 32'hFFFF_FFFF;
  localparam logic [5:0]  PREFIX_FULL  = 6'd32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [1:0]  mask_source;
    logic [5:0]  prefix_length;
    logic [31:0] explicit_mask;
    logic [2:0]  entry_index;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_local_address;
    logic        is_local_broadcast;
    logic [2:0]  match_index;
    logic [31:0] match_ip;
    logic [31:0] match_mask;
    logic [31:0] match_broadcast;
    logic [3:0]  entry_count;
  } result_t;

  // One table entry as held in the table RAM.
  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] mask;
    logic [31:0] broadcast;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath.
  typedef struct packed {
    logic load;    // take the request into the item register
    logic issue;   // a table read is issued this cycle
    logic finish;  // build the result and commit any table write
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic found;     // a selecting entry has been seen
    logic out_hold;  // the result register is full and stalled
  } status_t;

  // Address width of a table of the given depth.
  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width of a counter that holds 0 to n.
  function automatic int count_width(input int n);
    return $clog2(n + 1);
  endfunction

endpackage

// ===== design/ist_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module ist_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [ist_pkg::addr_width(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [ist_pkg::addr_width(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                        rdata
);
  import ist_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ist_datapath.sv =====
// ----------------------------------------------------------------------------
// Interface subnet table datapath
// Holds the request, the table RAM and entry count, compares each scanned
// entry against the request address and builds the registered result.
// ----------------------------------------------------------------------------
module ist_datapath #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  ist_pkg::request_t                                request,
  input  ist_pkg::cmd_t                                    cmd,
  input  logic [ist_pkg::addr_width(MAX_ENTRIES)-1:0]      raddr,
  output ist_pkg::status_t                                 status,
  output logic [ist_pkg::count_width(MAX_ENTRIES)-1:0]     used,
  output logic                                             result_valid,
  output ist_pkg::result_t                                 result,
  input  logic                                             result_stall
);
  import ist_pkg::*;

  localparam int AW = addr_width(MAX_ENTRIES);
  localparam int CW = count_width(MAX_ENTRIES);

  request_t         item;
  logic             chk_valid;
  logic [AW-1:0]    chk_idx;
  logic             found;
  logic             loc_hit;
  logic             bc_hit;
  logic [AW-1:0]    sel_idx;
  entry_t           sel;
  entry_t           first;

  logic [ENTRY_W-1:0] ram_q;
  entry_t           rd;
  logic [31:0]      new_mask;
  entry_t           new_entry;
  logic             hit;
  logic             full;
  logic             wr_en;
  entry_t           pick;
  logic [2:0]       pick_idx;
  result_t          res_next;

  assign rd   = entry_t'(ram_q);
  assign full = (used >= CW'(MAX_ENTRIES));

  // Netmask of an entry to be added.
  always_comb begin
    case (item.mask_source)
      MSRC_CLASSFUL: begin
        if (!item.address[31]) begin
          new_mask = MASK_CLASS_A;
        end else if (!item.address[30]) begin
          new_mask = MASK_CLASS_B;
        end else if (!item.address[29]) begin
          new_mask = MASK_CLASS_C;
        end else begin
          new_mask = MASK_CLASS_D;
        end
      end
      MSRC_PREFIX: begin
        if (item.prefix_length == '0) begin
          new_mask = '0;
        end else if (item.prefix_length >= PREFIX_FULL) begin
          new_mask = MASK_ONES;
        end else begin
          new_mask = MASK_ONES << (PREFIX_FULL - item.prefix_length);
        end
      end
      default: new_mask = item.explicit_mask;
    endcase
  end

  assign new_entry.ip        = item.address;
  assign new_entry.mask      = new_mask;
  assign new_entry.broadcast = item.address | ~new_mask;

  // Selection test for the entry returned by the RAM this cycle.
  always_comb begin
    case (item.mode)
      MODE_ADD:   hit = (rd.ip == item.address);
      MODE_QUERY: hit = (((rd.ip ^ item.address) & rd.mask) == '0);
      default:    hit = 1'b1;
    endcase
  end

  assign wr_en = cmd.finish && (item.mode == MODE_ADD) && !found && !full;

  ist_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(used)),
    .wdata(ENTRY_W'(new_entry)),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // A query falls back to entry 0 when nothing matched or the address is zero.
  always_comb begin
    if ((item.mode == MODE_QUERY) && (!found || (item.address == '0))) begin
      pick     = first;
      pick_idx = '0;
    end else begin
      pick     = sel;
      pick_idx = 3'(sel_idx);
    end
  end

  // Result of the current request.
  always_comb begin
    res_next             = '0;
    res_next.entry_count = 4'(used);
    case (item.mode)
      MODE_ADD: begin
        if (found) begin
          res_next.status          = ST_DUP;
          res_next.match_index     = pick_idx;
          res_next.match_ip        = pick.ip;
          res_next.match_mask      = pick.mask;
          res_next.match_broadcast = pick.broadcast;
        end else if (full) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.status          = ST_ADDED;
          res_next.match_index     = 3'(used);
          res_next.match_ip        = new_entry.ip;
          res_next.match_mask      = new_entry.mask;
          res_next.match_broadcast = new_entry.broadcast;
          res_next.entry_count     = 4'(used + CW'(1));
        end
      end
      MODE_QUERY: begin
        if (used == '0) begin
          res_next.status = ST_ERR;
        end else begin
          res_next.status             = ST_DONE;
          res_next.is_local_address   = loc_hit;
          res_next.is_local_broadcast = bc_hit;
          res_next.match_index        = pick_idx;
          res_next.match_ip           = pick.ip;
          res_next.match_mask         = pick.mask;
          res_next.match_broadcast    = pick.broadcast;
        end
      end
      MODE_READ: begin
        if (found) begin
          res_next.status          = ST_DONE;
          res_next.match_index     = pick_idx;
          res_next.match_ip        = pick.ip;
          res_next.match_mask      = pick.mask;
          res_next.match_broadcast = pick.broadcast;
        end else begin
          res_next.status = ST_ERR;
        end
      end
      default: res_next.status = ST_ERR;
    endcase
  end

  // Control state: entry count, read tracking, scan flags and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      chk_valid    <= 1'b0;
      found        <= 1'b0;
      loc_hit      <= 1'b0;
      bc_hit       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      chk_valid <= cmd.issue;
      if (wr_en) begin
        used <= used + CW'(1);
      end
      if (cmd.load) begin
        found   <= 1'b0;
        loc_hit <= 1'b0;
        bc_hit  <= 1'b0;
      end else if (chk_valid) begin
        if (hit) begin
          found <= 1'b1;
        end
        if (rd.ip == item.address) begin
          loc_hit <= 1'b1;
        end
        if (rd.broadcast == item.address) begin
          bc_hit <= 1'b1;
        end
      end
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers: request, captured entries and result.
  always_ff @(posedge clk) begin
    chk_idx <= raddr;
    if (cmd.load) begin
      item <= request;
    end
    if (!cmd.load && chk_valid) begin
      if (hit && !found) begin
        sel_idx <= chk_idx;
        sel     <= rd;
      end
      if (chk_idx == '0) begin
        first <= rd;
      end
    end
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  assign status.found    = found;
  assign status.out_hold = result_valid && result_stall;

endmodule

// ===== design/ist_ctrl.sv =====
// ----------------------------------------------------------------------------
// Interface subnet table controller
// Accepts a request, walks the table one entry per cycle through the RAM
// read port and tells the datapath when to finish the result.
// ----------------------------------------------------------------------------
module ist_ctrl #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           request_valid,
  input  logic [1:0]                                     request_mode,
  input  logic [2:0]                                     request_index,
  input  logic [ist_pkg::count_width(MAX_ENTRIES)-1:0]   used,
  input  ist_pkg::status_t                               status,
  output logic                                           request_stall,
  output ist_pkg::cmd_t                                  cmd,
  output logic [ist_pkg::addr_width(MAX_ENTRIES)-1:0]    raddr
);
  import ist_pkg::*;

  localparam int AW = addr_width(MAX_ENTRIES);
  localparam int CW = count_width(MAX_ENTRIES);
  localparam int XW = (CW > 3) ? CW : 3;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t        state;
  logic [1:0]    mode_q;
  logic [AW-1:0] cnt;

  logic idx_ok;
  logic last;
  logic dup_stop;

  assign idx_ok   = (XW'(request_index) < XW'(used));
  assign last     = (CW'(cnt) == (used - CW'(1)));
  assign dup_stop = (mode_q == MODE_ADD) && status.found;

  assign request_stall = (state != IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd.load   = (state == IDLE) && request_valid;
    cmd.finish = (state == FINISH) && !status.out_hold;
    cmd.issue  = 1'b0;
    raddr      = cnt;
    if (state == IDLE) begin
      raddr     = AW'(request_index);
      cmd.issue = request_valid && (request_mode == MODE_READ) && idx_ok;
    end else if (state == SCAN) begin
      cmd.issue = !dup_stop;
    end
  end

  // State machine and scan counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      mode_q <= MODE_ADD;
      cnt    <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (request_valid) begin
            mode_q <= request_mode;
            cnt    <= '0;
            unique case (request_mode)
              MODE_ADD, MODE_QUERY: begin
                state <= (used == '0) ? FINISH : SCAN;
              end
              MODE_READ: begin
                state <= idx_ok ? DRAIN : FINISH;
              end
              default: state <= FINISH;
            endcase
          end
        end
        SCAN: begin
          if (dup_stop) begin
            state <= FINISH;
          end else if (last) begin
            state <= DRAIN;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        DRAIN: begin
          state <= FINISH;
        end
        FINISH: begin
          if (!status.out_hold) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== design/interface_subnet_table_core.sv =====
// ----------------------------------------------------------------------------
// Interface subnet table
// A small table of local IPv4 interfaces (address, netmask, broadcast) with
// add, query and read-by-index requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on request/request_valid and is taken when request_stall
//   is low; one result per request leaves on result/result_valid and is taken
//   when result_stall is low. Requests are handled one at a time.
//   Add and query walk the table through the single read port of the table
//   RAM, one entry per cycle, then pass through the drain and finish states
//   before the result is valid; the next request is taken once the
//   controller is back in its idle state. An add that hits a duplicate
//   stops the walk early. A read of a held entry issues its table read
//   when the request is taken and passes through drain and finish; add or
//   query on an empty table, a read out of range and an unknown mode go straight to finish.
//   The result register is separate from the controller, so a new request is
//   taken while the previous result waits; while the receiver stalls, the
//   finished result of the following request is held back and request_stall
//   stays high.
//   Reset empties the table at once; entry contents are not cleared and are
//   only read once written.
// ----------------------------------------------------------------------------
module interface_subnet_table_core #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  ist_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output ist_pkg::result_t  result
);
  import ist_pkg::*;

  localparam int AW = addr_width(MAX_ENTRIES);
  localparam int CW = count_width(MAX_ENTRIES);

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] raddr;
  logic [CW-1:0] used;

  // Sequencer.
  ist_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_mode (request.mode),
    .request_index(request.entry_index),
    .used         (used),
    .status       (status),
    .request_stall(request_stall),
    .cmd          (cmd),
    .raddr        (raddr)
  );

  // Table, comparisons and result register.
  ist_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .cmd         (cmd),
    .raddr       (raddr),
    .status      (status),
    .used        (used),
    .result_valid(result_valid),
    .result      (result),
    .result_stall(result_stall)
  );

endmodule
